>>> hdl/brfifo_pkg.sv
// ----------------------------------------------------------------------------
// brfifo_pkg
// Shared types and constants for the byte ring FIFO: field widths, stream
// packing and the operation codes carried on the input tuser.
// ----------------------------------------------------------------------------
`default_nettype none

package brfifo_pkg;

    // Default ring storage depth in bytes.
    localparam int DEPTH_DEF = 64;

    // Field widths.
    localparam int FUNC_W   = 2;
    localparam int DATA_W   = 8;
    localparam int CNT_W    = 6;
    localparam int CAP_W    = 7;

    // Capacity register value after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Result tdata: data_out, used_count, empty_res, drained_total, then zero fill.
    localparam int RES_BITS = DATA_W + CNT_W + 1 + CNT_W;
    localparam int TDATA_W  = ((RES_BITS + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - RES_BITS;

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        F_PUT   = 2'd0,
        F_GET   = 2'd1,
        F_DRAIN = 2'd2,
        F_FLUSH = 2'd3
    } t_func;

endpackage : brfifo_pkg

`default_nettype wire

>>> hdl/byte_ring_fifo_unit.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_unit
// Byte ring FIFO with a programmable wrap point. One slot is always kept
// empty. Supports put, get, drain of all held bytes, and flush.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Signals                            | Contents
//  ---------+-----------+------------------------------------+---------------------------
//  s        | in        | i_s_tvalid/o_s_tready/tdata/tuser  | tdata data_in, tuser func
//  m        | out       | o_m_tvalid/i_m_tready/tdata/tuser  | result fields, tuser ok,
//           |           | o_m_tlast                          | tlast last
//  cfg      | in        | i_cfg_valid/o_cfg_ready/i_cfg_data | capacity register
//
//  Put, flush and any operation on an empty ring load their result into the output register directly.
//  A get passes through the registered read of the byte store before its result is loaded.
//  A drain returns every held byte, reading one byte per cycle
//  as long as the output side keeps taking results; stalls there pause the reads.
//  Reset is synchronous; the byte store is not cleared and needs no sweep.
//  A capacity write clears the ring and holds off the input side in its cycle.
//
`default_nettype none

module byte_ring_fifo_unit
    import brfifo_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    // Input stream.
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [DATA_W-1:0]    i_s_tdata,   // [7:0] data_in
    input  wire logic [FUNC_W-1:0]    i_s_tuser,   // [1:0] func

    // Result stream.
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [TDATA_W-1:0]        o_m_tdata,   // [7:0] data_out, [13:8] used_count,
                                                   // [14] empty_res, [20:15] drained_total
    output logic [0:0]                o_m_tuser,   // [0] ok
    output logic                      o_m_tlast,

    // Capacity register write.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CAP_W-1:0]     i_cfg_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } t_state;

    // Byte store and its registered read data.
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Control state.
    t_state            r_state,   n_state;
    logic [CAP_W-1:0]  r_cap,     n_cap;
    logic [PW-1:0]     r_wp,      n_wp;
    logic [PW-1:0]     r_rp,      n_rp;
    logic [PW-1:0]     r_held,    n_held;
    logic              r_drain,   n_drain;
    logic [PW-1:0]     r_total,   n_total;

    // Metadata for the byte whose read is in flight.
    logic              r_pend,    n_pend;
    logic [PW-1:0]     r_p_used,  n_p_used;
    logic              r_p_empty, n_p_empty;
    logic              r_p_last,  n_p_last;
    logic [PW-1:0]     r_p_drn,   n_p_drn;

    // Output register.
    logic              r_ov,      n_ov;
    logic [DATA_W-1:0] r_o_data,  n_o_data;
    logic              r_o_ok,    n_o_ok;
    logic [PW-1:0]     r_o_used,  n_o_used;
    logic              r_o_empty, n_o_empty;
    logic [PW-1:0]     r_o_drn,   n_o_drn;
    logic              r_o_last,  n_o_last;

    logic              out_free;
    logic              s_acc;
    logic              cfg_acc;
    logic              mem_we;
    logic              rd_en;
    logic              load_p;
    logic              more;
    logic [CAP_W-1:0]  cap_eff;
    logic [CAP_W-1:0]  wp_p1;
    logic [CAP_W-1:0]  rp_p1;
    logic [PW-1:0]     wp_inc;
    logic [PW-1:0]     rp_inc;
    logic [CAP_W-1:0]  diff;
    logic              put_ok;
    t_func             func;

    // Effective capacity: register value clamped to the storage range.
    always_comb begin
        priority if (r_cap < CAP_W'(2)) begin
            cap_eff = CAP_W'(2);
        end else if (r_cap > CAP_W'(DEPTH)) begin
            cap_eff = CAP_W'(DEPTH);
        end else begin
            cap_eff = r_cap;
        end
    end

    // Position increments with wrap at the effective capacity.
    assign wp_p1  = CAP_W'(r_wp) + CAP_W'(1);
    assign rp_p1  = CAP_W'(r_rp) + CAP_W'(1);
    assign wp_inc = (wp_p1 >= cap_eff) ? '0 : PW'(wp_p1);
    assign rp_inc = (rp_p1 >= cap_eff) ? '0 : PW'(rp_p1);

    // A put needs room for one more byte beyond the one empty slot.
    always_comb begin
        if (r_wp >= r_rp) begin
            diff = CAP_W'(r_wp) - CAP_W'(r_rp);
        end else begin
            diff = CAP_W'(r_wp) + cap_eff - CAP_W'(r_rp);
        end
    end
    assign put_ok = cap_eff > (diff + CAP_W'(1));

    // Handshakes. A capacity write goes first and holds off the input side.
    assign out_free    = !r_ov || i_m_tready;
    assign o_s_tready  = (r_state == S_IDLE) && out_free && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign func        = t_func'(i_s_tuser);

    // In the busy state, a pending byte moves to the output when it is free.
    assign load_p = r_pend && out_free;
    assign more   = r_drain && (r_rp != r_wp);

    // Next-state logic.
    always_comb begin
        n_state   = r_state;
        n_cap     = r_cap;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_held    = r_held;
        n_drain   = r_drain;
        n_total   = r_total;
        n_pend    = r_pend;
        n_p_used  = r_p_used;
        n_p_empty = r_p_empty;
        n_p_last  = r_p_last;
        n_p_drn   = r_p_drn;
        n_ov      = r_ov;
        n_o_data  = r_o_data;
        n_o_ok    = r_o_ok;
        n_o_used  = r_o_used;
        n_o_empty = r_o_empty;
        n_o_drn   = r_o_drn;
        n_o_last  = r_o_last;
        mem_we    = 1'b0;
        rd_en     = 1'b0;

        // Retire the output register when taken.
        if (r_ov && i_m_tready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    // Most operations load their result into the output register directly.
                    n_ov      = 1'b1;
                    n_o_data  = '0;
                    n_o_drn   = '0;
                    n_o_last  = 1'b1;
                    n_o_used  = r_held;
                    n_o_empty = (r_wp == r_rp);
                    n_o_ok    = 1'b0;
                    unique case (func)
                        F_PUT: begin
                            if (put_ok) begin
                                mem_we    = 1'b1;
                                n_wp      = wp_inc;
                                n_held    = r_held + PW'(1);
                                n_o_ok    = 1'b1;
                                n_o_used  = r_held + PW'(1);
                                n_o_empty = (wp_inc == r_rp);
                            end
                        end
                        F_GET, F_DRAIN: begin
                            if (r_wp != r_rp) begin
                                // Start the store read; the result follows.
                                n_ov      = r_ov && !i_m_tready;
                                rd_en     = 1'b1;
                                n_rp      = rp_inc;
                                n_held    = r_held - PW'(1);
                                n_pend    = 1'b1;
                                n_p_used  = r_held - PW'(1);
                                n_p_empty = (rp_inc == r_wp);
                                n_state   = S_BUSY;
                                if (func == F_DRAIN) begin
                                    n_drain  = 1'b1;
                                    n_total  = r_held;
                                    n_p_drn  = r_held;
                                    n_p_last = (rp_inc == r_wp);
                                end else begin
                                    n_drain  = 1'b0;
                                    n_p_drn  = '0;
                                    n_p_last = 1'b1;
                                end
                            end
                        end
                        F_FLUSH: begin
                            n_wp      = '0;
                            n_rp      = '0;
                            n_held    = '0;
                            n_o_ok    = 1'b1;
                            n_o_used  = '0;
                            n_o_empty = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_BUSY: begin
                // Hand the read byte to the output register.
                if (load_p) begin
                    n_ov      = 1'b1;
                    n_o_data  = r_rdata;
                    n_o_ok    = 1'b1;
                    n_o_used  = r_p_used;
                    n_o_empty = r_p_empty;
                    n_o_drn   = r_p_drn;
                    n_o_last  = r_p_last;
                    n_pend    = 1'b0;
                end
                // Keep one read in flight while a drain has bytes left.
                if (more && (!r_pend || load_p)) begin
                    rd_en     = 1'b1;
                    n_rp      = rp_inc;
                    n_held    = r_held - PW'(1);
                    n_pend    = 1'b1;
                    n_p_used  = r_held - PW'(1);
                    n_p_empty = (rp_inc == r_wp);
                    n_p_last  = (rp_inc == r_wp);
                    n_p_drn   = r_total;
                end else if (!more && (!r_pend || load_p)) begin
                    n_state = S_IDLE;
                    n_drain = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Capacity write also clears the ring.
        if (cfg_acc) begin
            n_cap  = i_cfg_data;
            n_wp   = '0;
            n_rp   = '0;
            n_held = '0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= CAP_RESET;
            r_wp    <= '0;
            r_rp    <= '0;
            r_held  <= '0;
            r_drain <= 1'b0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cap   <= n_cap;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_held  <= n_held;
            r_drain <= n_drain;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        r_total   <= n_total;
        r_p_used  <= n_p_used;
        r_p_empty <= n_p_empty;
        r_p_last  <= n_p_last;
        r_p_drn   <= n_p_drn;
        r_o_data  <= n_o_data;
        r_o_ok    <= n_o_ok;
        r_o_used  <= n_o_used;
        r_o_empty <= n_o_empty;
        r_o_drn   <= n_o_drn;
        r_o_last  <= n_o_last;
    end

    // Byte store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= i_s_tdata;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_rp];
        end
    end

    // Result stream outputs.
    assign o_m_tvalid   = r_ov;
    assign o_m_tdata    = {{PAD_W{1'b0}}, CNT_W'(r_o_drn), r_o_empty, CNT_W'(r_o_used),
                           r_o_data};
    assign o_m_tuser[0] = r_o_ok;
    assign o_m_tlast    = r_o_last;

    // The held count never reaches the effective capacity.
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CAP_W'(r_held) < cap_eff)
        else $error("held count reached capacity");

    // Equal positions mean an empty ring and nothing else.
    a_pos_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rp == r_wp) == (r_held == '0))
        else $error("positions and held count disagree");

    // A store read is only in flight while busy.
    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_BUSY))
        else $error("pending read outside busy state");

    // A get on a non-empty ring launches a read.
    a_get_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (func == F_GET) && (r_rp != r_wp) && !cfg_acc) |=> r_pend)
        else $error("get did not start a store read");

endmodule : byte_ring_fifo_unit

`default_nettype wire
